// ===== rtl/alt_pkg.sv =====
// Shared constants, codes and types for the array list table.
package alt_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 3;
    localparam int SORT_W     = $clog2(CAPACITY);

    localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_FIRST = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INS_SORT  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic [DATA_WIDTH-1:0] EMPTY_WORD = '1;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_OPEN,
        OP_CLOSE,
        OP_APPEND,
        OP_SORT
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [IDX_W-1:0]       pos;
        logic [CNT_W-1:0]       occ;
        logic                   phase;
        logic [DATA_WIDTH-1:0]  value;
    } t_ctl;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SORT = 2'b10
    } t_state;

endpackage

// ===== rtl/alt_cell.sv =====
// One storage cell of the list chain: shift, load and compare-exchange.
module alt_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [alt_pkg::IDX_W-1:0]     i_idx,
    input  alt_pkg::t_ctl                 i_ctl,
    input  logic [alt_pkg::DATA_WIDTH-1:0] i_left,
    input  logic [alt_pkg::DATA_WIDTH-1:0] i_right,
    output logic [alt_pkg::DATA_WIDTH-1:0] o_word,
    output logic                          o_match
);
    import alt_pkg::*;

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;
    logic [CNT_W-1:0]      w_idx;
    logic [CNT_W-1:0]      w_idx_up;
    logic                  w_lower;

    assign w_idx    = CNT_W'(i_idx);
    assign w_idx_up = w_idx + CNT_W'(1);
    assign w_lower  = (i_idx[0] == i_ctl.phase);

    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            OP_OPEN: begin
                if (i_idx == i_ctl.pos) begin
                    n_word = i_ctl.value;
                end else if (i_idx > i_ctl.pos && w_idx <= i_ctl.occ) begin
                    n_word = i_left;
                end
            end
            OP_CLOSE: begin
                // cells past the end already hold minus one
                if (i_idx >= i_ctl.pos) begin
                    n_word = i_right;
                end
            end
            OP_APPEND: begin
                if (w_idx == i_ctl.occ) begin
                    n_word = i_ctl.value;
                end
            end
            OP_SORT: begin
                // odd-even transposition over the occupied part
                if (w_lower) begin
                    if (w_idx_up < i_ctl.occ && $signed(r_word) > $signed(i_right)) begin
                        n_word = i_right;
                    end
                end else if (i_idx != '0 && w_idx < i_ctl.occ
                             && $signed(i_left) > $signed(r_word)) begin
                    n_word = i_left;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= EMPTY_WORD;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word  = r_word;
    assign o_match = (r_word == i_ctl.value);

endmodule

// ===== rtl/array_list_table.sv =====
// Top level of the array list table: command decode, cell chain and result register.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_cmd, i_value, i_position
//   result    out        o_valid / i_stall    o_status, o_found_index, o_read_value,
//                                             o_entry_count
//
// Every command but insert sorted has its result registered and shown the
// cycle after acceptance. Insert sorted first appends the value and then runs
// CAPACITY odd-even compare-exchange passes along the cell chain.
// Synchronous reset fills every cell with minus one and clears the count.
// A request is taken while no sort runs and the result register is empty or is being emptied.
module array_list_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [alt_pkg::CMD_W-1:0]       i_cmd,
    input  logic signed [alt_pkg::DATA_WIDTH-1:0] i_value,
    input  logic [alt_pkg::IDX_W-1:0]       i_position,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [alt_pkg::STAT_W-1:0]      o_status,
    output logic [alt_pkg::IDX_W-1:0]       o_found_index,
    output logic signed [alt_pkg::DATA_WIDTH-1:0] o_read_value,
    output logic [alt_pkg::CNT_W-1:0]       o_entry_count
);
    import alt_pkg::*;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_occ, n_occ;
    logic [SORT_W-1:0]      r_sort_cnt, n_sort_cnt;
    logic                   r_ovalid, n_ovalid;
    logic [STAT_W-1:0]      r_status, n_status;
    logic [IDX_W-1:0]       r_found, n_found;
    logic [DATA_WIDTH-1:0]  r_rd, n_rd;

    logic [DATA_WIDTH-1:0]  w_words [CAPACITY];
    logic [CAPACITY-1:0]    w_match;
    t_ctl                   w_ctl;
    logic                   w_accept;
    logic                   w_full;
    logic [CNT_W-1:0]       w_pos;
    logic                   w_hit;
    logic [IDX_W-1:0]       w_hit_idx;

    assign o_stall  = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_occ == CNT_W'(CAPACITY));
    assign w_pos    = CNT_W'(i_position);

    // first match within the occupied part
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (w_match[k] && CNT_W'(k) < r_occ) begin
                w_hit     = 1'b1;
                w_hit_idx = IDX_W'(k);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_occ      = r_occ;
        n_sort_cnt = r_sort_cnt;
        n_ovalid   = r_ovalid && i_stall;
        n_status   = r_status;
        n_found    = r_found;
        n_rd       = r_rd;

        w_ctl.op    = OP_HOLD;
        w_ctl.pos   = i_position;
        w_ctl.occ   = r_occ;
        w_ctl.phase = r_sort_cnt[0];
        w_ctl.value = i_value;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_found  = '0;
                    n_rd     = '0;
                    n_ovalid = 1'b1;
                    case (i_cmd)
                        CMD_INS_POS: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else if (w_pos > r_occ) begin
                                n_status = ST_BADPOS;
                            end else begin
                                w_ctl.op = OP_OPEN;
                                n_occ    = r_occ + CNT_W'(1);
                            end
                        end
                        CMD_INS_FIRST: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.op  = OP_OPEN;
                                w_ctl.pos = '0;
                                n_occ     = r_occ + CNT_W'(1);
                            end
                        end
                        CMD_DEL_POS: begin
                            if (r_occ == '0) begin
                                n_status = ST_EMPTY;
                            end else if (w_pos >= r_occ) begin
                                n_status = ST_BADPOS;
                            end else begin
                                w_ctl.op = OP_CLOSE;
                                n_occ    = r_occ - CNT_W'(1);
                            end
                        end
                        CMD_DEL_FIRST: begin
                            if (r_occ == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_ctl.op  = OP_CLOSE;
                                w_ctl.pos = '0;
                                n_occ     = r_occ - CNT_W'(1);
                            end
                        end
                        CMD_LOCATE: begin
                            if (w_hit) begin
                                n_found = w_hit_idx;
                            end else begin
                                n_status = ST_NOTFOUND;
                            end
                        end
                        CMD_INS_SORT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.op   = OP_APPEND;
                                n_occ      = r_occ + CNT_W'(1);
                                n_ovalid   = 1'b0;
                                n_sort_cnt = '0;
                                n_state    = S_SORT;
                            end
                        end
                        CMD_READ: begin
                            if (w_pos >= r_occ) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_rd = w_words[i_position];
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SORT: begin
                w_ctl.op   = OP_SORT;
                n_sort_cnt = r_sort_cnt + SORT_W'(1);
                if (r_sort_cnt == SORT_W'(CAPACITY - 1)) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = EMPTY_WORD;
        end else begin : g_mid_l
            assign w_left = w_words[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = EMPTY_WORD;
        end else begin : g_mid_r
            assign w_right = w_words[g+1];
        end

        alt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_words[g]),
            .o_match (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_occ      <= '0;
            r_sort_cnt <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_occ      <= n_occ;
            r_sort_cnt <= n_sort_cnt;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_found  <= n_found;
        r_rd     <= n_rd;
    end

    // count is reported as it stands once the request has completed
    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_read_value  = r_rd;
    assign o_entry_count = r_occ;

endmodule

// ===== verif/array_list_table_test.sv =====
// Self-checking testbench for the array list table: directed, fill/drain, back-pressure and random phases.
`timescale 1ns / 1ps

module array_list_table_test;
    import alt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 3 * (CAPACITY + 1);
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [STAT_W-1:0]            status;
        logic [IDX_W-1:0]             found_index;
        logic signed [DATA_WIDTH-1:0] read_value;
        logic [CNT_W-1:0]             entry_count;
    } t_list_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [CMD_W-1:0]             i_cmd;
    logic signed [DATA_WIDTH-1:0] i_value;
    logic [IDX_W-1:0]             i_position;
    logic                         o_valid;
    logic                         i_stall;
    logic [STAT_W-1:0]            o_status;
    logic [IDX_W-1:0]             o_found_index;
    logic signed [DATA_WIDTH-1:0] o_read_value;
    logic [CNT_W-1:0]             o_entry_count;

    // shadow of the list contents
    logic signed [DATA_WIDTH-1:0] list_words [CAPACITY];
    int                           list_len;
    t_list_result                 list_results_due [$];

    int   error_count;
    int   quiet_cycles = 0;
    logic req_gaps_on;
    logic rsp_stall_on;
    logic hold_off_req;

    array_list_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void report_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // mostly short, now and then a long one
    function automatic int pick_idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 1;
        end else if (r < 85) begin
            return $urandom_range(2, 4);
        end else if (r < 96) begin
            return $urandom_range(5, 12);
        end
        return $urandom_range(20, 48);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] pick_word();
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            s = $urandom_range(0, 8);
            return s - 4;
        end else if (r < 40) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 32'sh0;
                default: return -32'sh1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input logic grow);
        int r;
        r = $urandom_range(0, 99);
        if (grow) begin
            if (r < 18)      return CMD_INS_POS;
            else if (r < 32) return CMD_INS_FIRST;
            else if (r < 50) return CMD_INS_SORT;
            else if (r < 58) return CMD_DEL_POS;
            else if (r < 64) return CMD_DEL_FIRST;
            else if (r < 78) return CMD_LOCATE;
            else if (r < 97) return CMD_READ;
        end else begin
            if (r < 6)       return CMD_INS_POS;
            else if (r < 11) return CMD_INS_FIRST;
            else if (r < 17) return CMD_INS_SORT;
            else if (r < 40) return CMD_DEL_POS;
            else if (r < 55) return CMD_DEL_FIRST;
            else if (r < 72) return CMD_LOCATE;
            else if (r < 97) return CMD_READ;
        end
        return CMD_SPARE;
    endfunction

    function automatic logic [IDX_W-1:0] pick_position();
        if ($urandom_range(0, 99) < 80) begin
            return IDX_W'($urandom_range(0, (list_len > 15) ? 15 : list_len));
        end
        return IDX_W'($urandom_range(0, 15));
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] pick_search_word();
        if (list_len > 0 && $urandom_range(0, 99) < 60) begin
            return list_words[$urandom_range(0, list_len - 1)];
        end
        return pick_word();
    endfunction

    function automatic void open_slot(input int at, input logic signed [DATA_WIDTH-1:0] w);
        for (int i = list_len; i > at; i--) begin
            list_words[i] = list_words[i - 1];
        end
        list_words[at] = w;
        list_len++;
    endfunction

    function automatic void close_slot(input int at);
        for (int i = at; i + 1 < list_len; i++) begin
            list_words[i] = list_words[i + 1];
        end
        list_len--;
        list_words[list_len] = EMPTY_WORD;
    endfunction

    // updates the shadow list and returns the result the block should give
    function automatic t_list_result apply_list_command(
        input logic [CMD_W-1:0]             cmd,
        input logic signed [DATA_WIDTH-1:0] w,
        input logic [IDX_W-1:0]             pos
    );
        t_list_result                 res;
        logic signed [DATA_WIDTH-1:0] held;
        int                           j;
        res = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_INS_POS: begin
                if (list_len >= CAPACITY)        res.status = ST_FULL;
                else if (int'(pos) > list_len)   res.status = ST_BADPOS;
                else                             open_slot(int'(pos), w);
            end
            CMD_INS_FIRST: begin
                if (list_len >= CAPACITY)   res.status = ST_FULL;
                else                        open_slot(0, w);
            end
            CMD_DEL_POS: begin
                if (list_len == 0)               res.status = ST_EMPTY;
                else if (int'(pos) >= list_len)  res.status = ST_BADPOS;
                else                             close_slot(int'(pos));
            end
            CMD_DEL_FIRST: begin
                if (list_len == 0)          res.status = ST_EMPTY;
                else                        close_slot(0);
            end
            CMD_LOCATE: begin
                res.status = ST_NOTFOUND;
                for (int i = 0; i < list_len; i++) begin
                    if (list_words[i] == w) begin
                        res.status      = ST_OK;
                        res.found_index = IDX_W'(i);
                        break;
                    end
                end
            end
            CMD_INS_SORT: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_len] = w;
                    list_len++;
                    // whole list sorted, signed ascending
                    for (int i = 1; i < list_len; i++) begin
                        held = list_words[i];
                        j = i;
                        while (j > 0 && list_words[j - 1] > held) begin
                            list_words[j] = list_words[j - 1];
                            j--;
                        end
                        list_words[j] = held;
                    end
                end
            end
            CMD_READ: begin
                if (int'(pos) >= list_len)  res.status = ST_BADPOS;
                else                        res.read_value = list_words[pos];
            end
            default: ;
        endcase
        res.entry_count = CNT_W'(list_len);
        return res;
    endfunction

    // drives one request, waits for it to be taken, records what it should give
    task automatic send_request(
        input logic [CMD_W-1:0]             cmd,
        input logic signed [DATA_WIDTH-1:0] w,
        input logic [IDX_W-1:0]             pos
    );
        int gap;
        gap = (req_gaps_on && $urandom_range(0, 99) < 30) ? pick_idle_span() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= w;
        i_position <= pos;
        do @(posedge i_clk); while (o_stall);
        list_results_due.push_back(apply_list_command(cmd, w, pos));
    endtask

    task automatic send_random_request(input logic grow);
        logic [CMD_W-1:0] cmd;
        cmd = pick_command(grow);
        send_request(cmd, (cmd == CMD_LOCATE) ? pick_search_word() : pick_word(),
                     pick_position());
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (list_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_list();
        req_gaps_on  = 1'b0;
        rsp_stall_on = 1'b0;
        send_request(CMD_READ,      32'sh0,            4'd0);
        send_request(CMD_DEL_POS,   32'sh0,            4'd0);
        send_request(CMD_DEL_FIRST, 32'sh0,            4'd15);
        send_request(CMD_LOCATE,    -32'sh1,           4'd0);
        send_request(CMD_SPARE,     32'sh12345678,     4'd9);
        send_request(CMD_INS_POS,   32'sh1,            4'd1);
        send_request(CMD_INS_POS,   32'sh7fffffff,     4'd15);
        drain_results();
    endtask

    task automatic test_basic_ops();
        send_request(CMD_INS_POS,   32'sh7fffffff,     4'd0);
        send_request(CMD_INS_FIRST, 32'sh80000000,     4'd7);
        send_request(CMD_INS_POS,   32'sh0,            4'd2);   // append at the end
        send_request(CMD_INS_SORT,  -32'sh1,           4'd0);
        send_request(CMD_INS_POS,   32'sh55555555,     4'd1);
        send_request(CMD_LOCATE,    32'sh80000000,     4'd0);
        send_request(CMD_LOCATE,    -32'sh1,           4'd0);
        send_request(CMD_LOCATE,    32'sh00012345,     4'd0);
        send_request(CMD_READ,      32'sh0,            4'd0);
        send_request(CMD_READ,      32'sh0,            4'd4);
        send_request(CMD_READ,      32'sh0,            4'd5);
        send_request(CMD_READ,      32'sh0,            4'd15);
        send_request(CMD_DEL_POS,   32'sh0,            4'd6);
        send_request(CMD_DEL_POS,   32'sh0,            4'd1);
        send_request(CMD_DEL_FIRST, 32'sh0,            4'd0);
        send_request(CMD_INS_SORT,  32'shaaaaaaaa,     4'd3);
        send_request(CMD_SPARE,     -32'sh1,           4'd15);
        drain_results();
    endtask

    task automatic test_fill_and_drain();
        req_gaps_on  = 1'b1;
        rsp_stall_on = 1'b1;
        while (list_len < CAPACITY) begin
            send_request(CMD_INS_SORT, pick_word(), IDX_W'($urandom_range(0, 15)));
        end
        send_request(CMD_INS_POS,   pick_word(), 4'd0);
        send_request(CMD_INS_FIRST, pick_word(), 4'd3);
        send_request(CMD_INS_SORT,  pick_word(), 4'd15);
        for (int p = 0; p < CAPACITY; p++) begin
            send_request(CMD_READ, pick_word(), IDX_W'(p));
        end
        send_request(CMD_LOCATE, list_words[CAPACITY - 1], 4'd0);
        while (list_len > 0) begin
            if ($urandom_range(0, 1)) begin
                send_request(CMD_DEL_FIRST, pick_word(), pick_position());
            end else begin
                send_request(CMD_DEL_POS, pick_word(),
                             IDX_W'($urandom_range(0, list_len - 1)));
            end
        end
        send_request(CMD_DEL_FIRST, pick_word(), 4'd0);
        drain_results();
    endtask

    // receiver holds off while requests keep coming, so the block backs up
    task automatic test_back_pressure();
        req_gaps_on  = 1'b0;
        rsp_stall_on = 1'b0;
        hold_off_req = 1'b1;
        repeat (12) send_random_request(1'b1);
        drain_results();
    endtask

    task automatic test_random_mix(input int count);
        logic grow;
        grow = 1'b1;
        for (int k = 0; k < count; k++) begin
            if (k % 200 == 0) begin
                req_gaps_on  = ((k / 200) % 4) inside {1, 3};
                rsp_stall_on = ((k / 200) % 4) inside {2, 3};
            end
            if (list_len == CAPACITY)            grow = 1'b0;
            else if (list_len == 0)              grow = 1'b1;
            else if ($urandom_range(0, 99) < 3)  grow = ~grow;
            send_random_request(grow);
        end
        drain_results();
    endtask

    initial begin : result_stall_drive
        int span;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else if (rsp_stall_on && $urandom_range(0, 99) < 20) begin
                span = pick_idle_span();
                i_stall <= 1'b1;
                repeat (span - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (list_results_due.size() == 0) begin
                report_failure($sformatf("unexpected result: status %0d idx %0d read %0d count %0d",
                               o_status, o_found_index, o_read_value, o_entry_count));
            end else begin
                want = list_results_due.pop_front();
                if (o_status !== want.status || o_found_index !== want.found_index ||
                    o_read_value !== want.read_value || o_entry_count !== want.entry_count) begin
                    report_failure($sformatf(
                        "mismatch: want status %0d idx %0d read %0d count %0d, got %0d %0d %0d %0d",
                        want.status, want.found_index, want.read_value, want.entry_count,
                        o_status, o_found_index, o_read_value, o_entry_count));
                end
            end
        end
    end

    // no request or result taken for too long means the block has hung
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("array_list_table_test: done, errors");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cmd        = CMD_READ;
        i_value      = '0;
        i_position   = '0;
        req_gaps_on  = 1'b0;
        rsp_stall_on = 1'b0;
        hold_off_req = 1'b0;
        error_count  = 0;
        foreach (list_words[k]) list_words[k] = EMPTY_WORD;
        list_len = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_basic_ops();
        test_fill_and_drain();
        test_back_pressure();
        test_random_mix(1600);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (list_results_due.size() != 0) begin
            report_failure($sformatf("%0d results never arrived", list_results_due.size()));
        end
        if (error_count == 0) begin
            $display("array_list_table_test: done, clean");
        end else begin
            $display("array_list_table_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/alt_pkg.sv
rtl/alt_cell.sv
rtl/array_list_table.sv
verif/array_list_table_test.sv
